[design/ipsl_pkg.sv]
// Shared types, constants and width helpers of the incremental PID speed limiter.
// Used by the channel interfaces and every module of the block; depends on nothing.
`default_nettype none

package ipsl_pkg;

	// Default width of the error samples
	localparam int ERROR_BITS_DEF = 16;

	// Register file layout
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int GAIN_W     = 16;
	localparam int SPEED_W    = 15;

	// Datapath constants
	localparam int SPEED_OUT_W = 16;
	localparam int OUT_ACC_W   = 32;
	localparam int COEF_W      = 27;        // signed width of the inner factors
	localparam int UNITY_Q16   = 65536;     // 1.0 in Q.16
	localparam int TD_SHIFT    = 8;         // Td Q8.8 to Q.16
	localparam int ROUND_SHIFT = 24;        // Q.24 product scale
	localparam int ROUND_HALF  = 8388608;   // 0.5 in Q.24

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KP       = 3'd0,
		REG_HALF_ITI = 3'd1,
		REG_TD       = 3'd2,
		REG_TOP      = 3'd3,
		REG_MIN      = 3'd4,
		REG_SEP      = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [GAIN_W-1:0]  kp;
		logic [GAIN_W-1:0]  half_iti;
		logic [GAIN_W-1:0]  td;
		logic [SPEED_W-1:0] top_speed;
		logic [SPEED_W-1:0] min_speed;
		logic [SPEED_W-1:0] sep_thr;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		kp:        16'd256,
		half_iti:  16'd0,
		td:        16'd0,
		top_speed: 15'd1500,
		min_speed: 15'd200,
		sep_thr:   15'd15
	};

	// Shared multiply-accumulate operations
	typedef enum logic [1:0] {
		MAC_LOAD,
		MAC_ADD,
		MAC_ADD_HI
	} mac_op_t;

	typedef struct packed {
		logic    en;
		mac_op_t op;
	} mac_ctrl_t;

	// Width of the multiplier's A operand: holds a sign-extended error and
	// either half of the inner sum
	function automatic int mul_a_width(input int eb);
		int w;
		begin
			w = (eb + 30) / 2;
			mul_a_width = (eb + 1 > w) ? eb + 1 : w;
		end
	endfunction

	// Inner sum width (errors times Q.16 factors)
	function automatic int inner_width(input int eb);
		inner_width = eb + 28;
	endfunction

	// Full product accumulator width (inner sum times Kp)
	function automatic int mac_acc_width(input int eb);
		mac_acc_width = eb + 28 + GAIN_W + 1;
	endfunction

endpackage

`default_nettype wire

[design/ipsl_err_if.sv]
// Input channel of the speed limiter: one signed error sample per request.
// Depends on ipsl_pkg for the default sample width.
`default_nettype none

interface ipsl_err_if #(
	parameter int ERROR_BITS = ipsl_pkg::ERROR_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [ERROR_BITS-1:0] error_in;

	modport source (output valid, output error_in, input ready);
	modport sink   (input valid, input error_in, output ready);
endinterface

`default_nettype wire

[design/ipsl_speed_if.sv]
// Output channel of the speed limiter: speed command and integral flag.
// Depends on ipsl_pkg for the speed width.
`default_nettype none

interface ipsl_speed_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [ipsl_pkg::SPEED_OUT_W-1:0] speed_out;
	logic                                    integral_active;

	modport source (output valid, output speed_out, output integral_active, input ready);
	modport sink   (input valid, input speed_out, input integral_active, output ready);
endinterface

`default_nettype wire

[design/incremental_pid_speed_limiter.sv]
// Incremental PID speed limiter with integral separation, top level.
// Depends on ipsl_pkg, ipsl_err_if, ipsl_speed_if, ipsl_cfg, ipsl_mac, ipsl_ctrl.
//
//   channel    dir  handshake      payload
//   error_ch   in   valid/ready    error_in (ERROR_BITS, signed)
//   speed_ch   out  valid/ready    speed_out (16, signed), integral_active
//   cfg        in   cfg_we         cfg_index (3), cfg_data (16)
//
// From request to the next ready, one error sample passes through ten steps of
// a sequencer that drives one shared 27-bit by A-operand multiplier five times,
// each product registered before it is accumulated, then round, saturate, clamp.
// Results sit in an output register; a new request is taken while one waits.
// A step stalls in its last state until the output register is free.
// arst_n clears the sequencer, the accumulator and the error history at once.
`default_nettype none

module incremental_pid_speed_limiter #(
	parameter int ERROR_BITS = ipsl_pkg::ERROR_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	ipsl_err_if.sink                             error_ch,
	ipsl_speed_if.source                         speed_ch,
	input  wire logic                            cfg_we,
	input  wire logic [ipsl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ipsl_pkg::CFG_DATA_W-1:0] cfg_data
);
	import ipsl_pkg::*;

	localparam int A_W   = mul_a_width(ERROR_BITS);
	localparam int ACC_W = mac_acc_width(ERROR_BITS);

	cfg_t                     cfg;
	mac_ctrl_t                mac_ctrl;
	logic signed [A_W-1:0]    op_a;
	logic signed [COEF_W-1:0] op_b;
	logic signed [ACC_W-1:0]  mac_acc;

	ipsl_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	ipsl_mac #(
		.A_W      (A_W),
		.B_W      (COEF_W),
		.ACC_W    (ACC_W),
		.HI_SHIFT (A_W - 1)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (mac_ctrl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (mac_acc)
	);

	ipsl_ctrl #(
		.ERROR_BITS (ERROR_BITS),
		.A_W        (A_W),
		.ACC_W      (ACC_W)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.err_ch   (error_ch),
		.spd_ch   (speed_ch),
		.mac_ctrl (mac_ctrl),
		.op_a     (op_a),
		.op_b     (op_b),
		.mac_acc  (mac_acc)
	);

endmodule

`default_nettype wire

[design/ipsl_cfg.sv]
// Configuration register file of the speed limiter.
// Depends on ipsl_pkg for the register layout and reset values.
`default_nettype none

module ipsl_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [ipsl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [ipsl_pkg::CFG_DATA_W-1:0] cfg_data,
	output ipsl_pkg::cfg_t                      cfg
);
	import ipsl_pkg::*;

	cfg_t cfg_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_KP:       cfg_q.kp        <= cfg_data[GAIN_W-1:0];
				REG_HALF_ITI: cfg_q.half_iti  <= cfg_data[GAIN_W-1:0];
				REG_TD:       cfg_q.td        <= cfg_data[GAIN_W-1:0];
				REG_TOP:      cfg_q.top_speed <= cfg_data[SPEED_W-1:0];
				REG_MIN:      cfg_q.min_speed <= cfg_data[SPEED_W-1:0];
				REG_SEP:      cfg_q.sep_thr   <= cfg_data[SPEED_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[design/ipsl_mac.sv]
// Shared multiply-accumulate unit: one registered signed multiplier feeding a
// wide accumulator. Depends on ipsl_pkg for the operation codes.
`default_nettype none

module ipsl_mac #(
	parameter int A_W      = 23,
	parameter int B_W      = 27,
	parameter int ACC_W    = 61,
	parameter int HI_SHIFT = 22
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire ipsl_pkg::mac_ctrl_t      ctrl,
	input  wire logic signed [A_W-1:0]    op_a,
	input  wire logic signed [B_W-1:0]    op_b,
	output logic signed [ACC_W-1:0]       acc
);
	import ipsl_pkg::*;

	localparam int P_W = A_W + B_W;

	mac_ctrl_t               ctrl_s1;
	logic signed [P_W-1:0]   prod_s1;
	logic signed [ACC_W-1:0] prod_ext;
	logic signed [ACC_W-1:0] addend;
	logic signed [ACC_W-1:0] acc_q;

	// Operation code is registered alongside its product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '{en: 1'b0, op: MAC_LOAD};
		end else begin
			ctrl_s1 <= ctrl;
		end
	end

	// Product register
	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	// Upper half of a split operand lands HI_SHIFT bits up
	always_comb begin
		prod_ext = ACC_W'(prod_s1);
		case (ctrl_s1.op)
			MAC_ADD_HI: addend = prod_ext <<< HI_SHIFT;
			default:    addend = prod_ext;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl_s1.en) begin
			case (ctrl_s1.op)
				MAC_LOAD: acc_q <= addend;
				default:  acc_q <= acc_q + addend;
			endcase
		end
	end

	assign acc = acc_q;

endmodule

`default_nettype wire

[design/ipsl_ctrl.sv]
// Sequencer and step datapath of the speed limiter: operand selection for the
// shared MAC, rounding, saturating accumulator, clamp and lift, output register.
// Depends on ipsl_pkg, ipsl_err_if and ipsl_speed_if.
`default_nettype none

module ipsl_ctrl #(
	parameter int ERROR_BITS = ipsl_pkg::ERROR_BITS_DEF,
	parameter int A_W        = ipsl_pkg::mul_a_width(ipsl_pkg::ERROR_BITS_DEF),
	parameter int ACC_W      = ipsl_pkg::mac_acc_width(ipsl_pkg::ERROR_BITS_DEF)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ipsl_pkg::cfg_t                  cfg,
	ipsl_err_if.sink                             err_ch,
	ipsl_speed_if.source                         spd_ch,
	output ipsl_pkg::mac_ctrl_t                  mac_ctrl,
	output logic signed [A_W-1:0]                op_a,
	output logic signed [ipsl_pkg::COEF_W-1:0]   op_b,
	input  wire logic signed [ACC_W-1:0]         mac_acc
);
	import ipsl_pkg::*;

	localparam int EB     = ERROR_BITS;
	localparam int LOW    = A_W - 1;
	localparam int S_W    = inner_width(ERROR_BITS);
	localparam int INC_W  = ACC_W - ROUND_SHIFT;
	localparam int SUM_W  = ((INC_W > OUT_ACC_W) ? INC_W : OUT_ACC_W) + 1;
	localparam int CMP_W  = EB + SPEED_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_M0,
		ST_M1,
		ST_M2,
		ST_WAIT_S,
		ST_M4,
		ST_M5,
		ST_WAIT_T,
		ST_ROUND,
		ST_SAT,
		ST_OUT
	} state_t;

	state_t                           state_q;
	logic signed [EB-1:0]             e_q;
	logic signed [EB-1:0]             e1_q;
	logic signed [EB-1:0]             e2_q;
	logic signed [OUT_ACC_W-1:0]      out_acc_q;
	logic signed [INC_W-1:0]          inc_q;
	logic signed [SPEED_OUT_W-1:0]    speed_q;
	logic                             integ_q;
	logic                             out_valid_q;

	logic signed [EB:0]               e_ext;
	logic [EB:0]                      e_mag;
	logic                             flag;
	logic [GAIN_W-1:0]                ipart;
	logic signed [COEF_W-1:0]         in0;
	logic signed [COEF_W-1:0]         in1;
	logic signed [COEF_W-1:0]         td_coef;
	logic signed [COEF_W-1:0]         kp_coef;
	logic signed [ACC_W-1:0]          rnd;
	logic signed [SUM_W-1:0]          sum;
	logic signed [OUT_ACC_W-1:0]      sat_acc;
	logic signed [OUT_ACC_W-1:0]      top_s;
	logic signed [OUT_ACC_W-1:0]      clamp;
	logic signed [SPEED_OUT_W-1:0]    sp;
	logic signed [SPEED_OUT_W-1:0]    mn;
	logic signed [SPEED_OUT_W-1:0]    sp_lift;
	logic [SPEED_OUT_W-1:0]           out_mag;

	// Integral separation: |e| below threshold
	assign e_ext = {e_q[EB-1], e_q};
	assign e_mag = e_q[EB-1] ? -e_ext : e_ext;
	assign flag  = CMP_W'(e_mag) < CMP_W'(cfg.sep_thr);
	assign ipart = flag ? cfg.half_iti : '0;

	// Inner factors in Q.16
	assign td_coef = COEF_W'(cfg.td) <<< TD_SHIFT;
	assign in0     = COEF_W'(UNITY_Q16) + COEF_W'(ipart) + td_coef;
	assign in1     = COEF_W'(UNITY_Q16) - COEF_W'(ipart) + (td_coef <<< 1);
	assign kp_coef = COEF_W'(cfg.kp);

	// Operand selection for the shared MAC
	always_comb begin
		mac_ctrl = '{en: 1'b0, op: MAC_LOAD};
		op_a     = '0;
		op_b     = '0;
		case (state_q)
			ST_M0: begin
				mac_ctrl = '{en: 1'b1, op: MAC_LOAD};
				op_a     = A_W'(e_q);
				op_b     = in0;
			end
			ST_M1: begin
				mac_ctrl = '{en: 1'b1, op: MAC_ADD};
				op_a     = A_W'(e1_q);
				op_b     = -in1;
			end
			ST_M2: begin
				mac_ctrl = '{en: 1'b1, op: MAC_ADD};
				op_a     = A_W'(e2_q);
				op_b     = td_coef;
			end
			ST_M4: begin
				// low half of the inner sum, unsigned
				mac_ctrl = '{en: 1'b1, op: MAC_LOAD};
				op_a     = $signed({1'b0, mac_acc[LOW-1:0]});
				op_b     = kp_coef;
			end
			ST_M5: begin
				// high half, signed, weighted by 2^LOW in the MAC
				mac_ctrl = '{en: 1'b1, op: MAC_ADD_HI};
				op_a     = A_W'($signed(mac_acc[S_W-1:LOW]));
				op_b     = kp_coef;
			end
			default: begin
			end
		endcase
	end

	// Round to nearest, ties up, out of Q.24
	assign rnd = mac_acc + ACC_W'(ROUND_HALF);

	// Saturating 32-bit accumulator update
	always_comb begin
		sum = SUM_W'(out_acc_q) + SUM_W'(inc_q);
		if ((&sum[SUM_W-1:OUT_ACC_W-1]) || !(|sum[SUM_W-1:OUT_ACC_W-1])) begin
			sat_acc = sum[OUT_ACC_W-1:0];
		end else if (sum[SUM_W-1]) begin
			sat_acc = {1'b1, {(OUT_ACC_W-1){1'b0}}};
		end else begin
			sat_acc = {1'b0, {(OUT_ACC_W-1){1'b1}}};
		end
	end

	// Clamp to top speed, then lift small nonzero values to min speed
	always_comb begin
		top_s = {{(OUT_ACC_W-SPEED_W){1'b0}}, cfg.top_speed};
		if (out_acc_q > top_s) begin
			clamp = top_s;
		end else if (out_acc_q < -top_s) begin
			clamp = -top_s;
		end else begin
			clamp = out_acc_q;
		end
		sp = clamp[SPEED_OUT_W-1:0];
		mn = {1'b0, cfg.min_speed};
		if (sp < 0 && sp > -mn) begin
			sp_lift = -mn;
		end else if (sp > 0 && sp < mn) begin
			sp_lift = mn;
		end else begin
			sp_lift = sp;
		end
	end

	// Sequencer, step state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			e_q         <= '0;
			e1_q        <= '0;
			e2_q        <= '0;
			out_acc_q   <= '0;
			inc_q       <= '0;
			speed_q     <= '0;
			integ_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			// drain the output register; ST_OUT refills it itself
			if (out_valid_q && spd_ch.ready && state_q != ST_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (err_ch.valid) begin
						e_q     <= err_ch.error_in;
						state_q <= ST_M0;
					end
				end
				ST_M0:     state_q <= ST_M1;
				ST_M1:     state_q <= ST_M2;
				ST_M2:     state_q <= ST_WAIT_S;
				ST_WAIT_S: state_q <= ST_M4;
				ST_M4:     state_q <= ST_M5;
				ST_M5:     state_q <= ST_WAIT_T;
				ST_WAIT_T: state_q <= ST_ROUND;
				ST_ROUND: begin
					inc_q   <= rnd[ACC_W-1:ROUND_SHIFT];
					state_q <= ST_SAT;
				end
				ST_SAT: begin
					out_acc_q <= sat_acc;
					e2_q      <= e1_q;
					e1_q      <= e_q;
					state_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (!out_valid_q || spd_ch.ready) begin
						speed_q     <= sp_lift;
						integ_q     <= flag;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign err_ch.ready           = (state_q == ST_IDLE);
	assign spd_ch.valid           = out_valid_q;
	assign spd_ch.speed_out       = speed_q;
	assign spd_ch.integral_active = integ_q;

	assign out_mag = speed_q[SPEED_OUT_W-1] ? SPEED_OUT_W'(-speed_q) : speed_q;

	// A request starts a multi-cycle step: no second request right behind it
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(err_ch.valid && err_ch.ready) |=> !err_ch.ready)
		else $error("input taken while a step is running");

	// Nonzero commands never sit inside the deadband
	a_deadband_lift: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_mag == '0) || (out_mag >= {1'b0, cfg.min_speed}))
		else $error("nonzero speed below min speed");

	// Magnitude bounded by top speed unless lifted to min speed
	a_top_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_mag <= {1'b0, cfg.top_speed}) ||
			(out_mag == {1'b0, cfg.min_speed}))
		else $error("speed above top speed");

endmodule

`default_nettype wire

[bench/incremental_pid_speed_limiter_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for the incremental PID speed limiter: directed table, then random phases.
// Depends on ipsl_pkg, ipsl_err_if, ipsl_speed_if and the incremental_pid_speed_limiter RTL.

module incremental_pid_speed_limiter_tb;
	import ipsl_pkg::*;

	localparam int ERR_W           = ERROR_BITS_DEF;
	localparam int RAND_PHASES     = 11;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int LONG_HOLD       = 400;
	localparam int SETTLE_CYCLES   = 3;
	localparam int DRAIN_CYCLES    = 30;
	localparam int WATCHDOG_LIMIT  = 2000;

	// Indexes past the register file; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	// Q formats of the coefficient math
	localparam longint Q16_ONE  = 65536;
	localparam longint Q24_HALF = 8388608;
	localparam longint ACC_MAX  = (longint'(1) <<< 31) - 1;
	localparam longint ACC_MIN  = -(longint'(1) <<< 31);

	typedef struct packed {
		logic signed [SPEED_OUT_W-1:0] speed;
		logic                          integral;
	} speed_cmd_t;

	typedef enum logic {
		ROW_SAMPLE,
		ROW_WRITE
	} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic [CFG_IDX_W-1:0]    index;
		logic [CFG_DATA_W-1:0]   data;
		logic signed [ERR_W-1:0] err;
		logic                    typed;
		speed_cmd_t              want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	ipsl_err_if   err_ch();
	ipsl_speed_if speed_ch();

	incremental_pid_speed_limiter u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.error_ch  (err_ch),
		.speed_ch  (speed_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Controller copy: configuration, accumulator and error history
	longint kp_cfg, iti_cfg, td_cfg, top_cfg, min_cfg, sep_cfg;
	longint speed_acc, prev_err, older_err;

	speed_cmd_t expected_speed_q[$];
	speed_cmd_t no_cmd = '{speed: '0, integral: 1'b0};
	int         fail_count = 0;
	int         burst_left = 0;
	bit         hold_off_req = 1'b0;

	// One control step: coefficients, exact increment, saturation, clamp and lift
	function automatic speed_cmd_t compute_speed_command(input logic signed [ERR_W-1:0] err);
		longint e, mag, ipart, c0, c1, c2, sum, sp;
		speed_cmd_t cmd;
		e = err;
		mag = (e < 0) ? -e : e;
		cmd.integral = (mag < sep_cfg);
		ipart = cmd.integral ? iti_cfg : 0;
		c0 = kp_cfg * (Q16_ONE + ipart + (td_cfg << 8));
		c1 = kp_cfg * (Q16_ONE - ipart + (td_cfg << 9));
		c2 = kp_cfg * (td_cfg << 8);
		sum = c0 * e - c1 * prev_err + c2 * older_err;
		// round to nearest, ties up: floor of (sum + 1/2) in Q.24
		speed_acc = speed_acc + ((sum + Q24_HALF) >>> 24);
		if (speed_acc > ACC_MAX) speed_acc = ACC_MAX;
		if (speed_acc < ACC_MIN) speed_acc = ACC_MIN;
		older_err = prev_err;
		prev_err = e;
		// clamp first, lift nonzero values below the minimum second
		sp = speed_acc;
		if (sp > top_cfg) sp = top_cfg;
		if (sp < -top_cfg) sp = -top_cfg;
		if (sp > -min_cfg && sp < 0) sp = -min_cfg;
		if (sp < min_cfg && sp > 0) sp = min_cfg;
		cmd.speed = sp[SPEED_OUT_W-1:0];
		return cmd;
	endfunction

	function automatic stim_row_t sample_row(input logic signed [ERR_W-1:0] err);
		stim_row_t r;
		r = '0;
		r.kind = ROW_SAMPLE;
		r.err = err;
		return r;
	endfunction

	function automatic stim_row_t checked_row(input logic signed [ERR_W-1:0] err,
			input logic signed [SPEED_OUT_W-1:0] speed, input logic integral);
		stim_row_t r;
		r = sample_row(err);
		r.typed = 1'b1;
		r.want = '{speed: speed, integral: integral};
		return r;
	endfunction

	function automatic stim_row_t write_row(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		stim_row_t r;
		r = '0;
		r.kind = ROW_WRITE;
		r.index = index;
		r.data = data;
		return r;
	endfunction

	// Random register value; narrow registers get a random bit above their width
	function automatic logic [CFG_DATA_W-1:0] pick_setting(input int unsigned typical_max,
			input bit narrow);
		logic [CFG_DATA_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = '0;
			1: v = '1;
			default: v = CFG_DATA_W'($urandom_range(0, typical_max));
		endcase
		if (narrow) v[CFG_DATA_W-1] = 1'($urandom_range(0, 1));
		return v;
	endfunction

	// Errors: full range, extremes, or near the separation threshold
	function automatic logic signed [ERR_W-1:0] random_error();
		bit [31:0] r;
		int span, v;
		case ($urandom_range(0, 7))
			0, 1: begin
				r = $urandom;
				v = int'(r);
			end
			2: v = $urandom_range(0, 1) ? 32767 : -32768;
			default: begin
				span = ($urandom_range(0, 3) == 0) ? 400 : int'(sep_cfg) + 2;
				if (span > 2000) span = 2000;
				v = int'($urandom_range(0, 2 * span)) - span;
			end
		endcase
		return v[ERR_W-1:0];
	endfunction

	// Sender: bursts of requests separated by random gaps
	task automatic send_error(input logic signed [ERR_W-1:0] err, input logic typed,
			input speed_cmd_t want);
		int gap;
		speed_cmd_t cmd;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				err_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		err_ch.valid <= 1'b1;
		err_ch.error_in <= err;
		do @(posedge clk); while (!err_ch.ready);
		cmd = compute_speed_command(err);
		expected_speed_q.push_back(typed ? want : cmd);
		burst_left--;
		@(negedge clk);
	endtask

	// Stop sending and let every outstanding request come back
	task automatic wait_until_drained();
		if (err_ch.valid) err_ch.valid <= 1'b0;
		burst_left = 0;
		while (expected_speed_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Leaves cfg_we high; the caller lowers it after the last write
	task automatic write_register(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(negedge clk);
		case (index)
			REG_KP:       kp_cfg = data;
			REG_HALF_ITI: iti_cfg = data;
			REG_TD:       td_cfg = data;
			REG_TOP:      top_cfg = data[SPEED_W-1:0];
			REG_MIN:      min_cfg = data[SPEED_W-1:0];
			REG_SEP:      sep_cfg = data[SPEED_W-1:0];
			default: ;
		endcase
	endtask

	// Stimulus
	initial begin : stimulus
		stim_row_t directed[$];
		bit writing;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		err_ch.valid = 1'b0;
		err_ch.error_in = '0;
		kp_cfg = CFG_RESET.kp;
		iti_cfg = CFG_RESET.half_iti;
		td_cfg = CFG_RESET.td;
		top_cfg = CFG_RESET.top_speed;
		min_cfg = CFG_RESET.min_speed;
		sep_cfg = CFG_RESET.sep_thr;
		speed_acc = 0;
		prev_err = 0;
		older_err = 0;
		writing = 1'b0;

		// Reset gains give unity gain: the output follows the latest error
		directed = '{
			checked_row(0, 0, 1'b1),            // zero is never lifted
			checked_row(1, 200, 1'b1),          // lifted to min speed
			checked_row(-1, -200, 1'b1),
			checked_row(14, 200, 1'b1),         // just inside separation
			checked_row(15, 200, 1'b0),         // at threshold: integral off
			checked_row(-15, -200, 1'b0),
			checked_row(199, 200, 1'b0),
			checked_row(201, 201, 1'b0),
			checked_row(-200, -200, 1'b0),
			checked_row(32767, 1500, 1'b0),     // clamped to top speed
			checked_row(-32768, -1500, 1'b0),
			checked_row(1500, 1500, 1'b0),
			checked_row(-1501, -1500, 1'b0),
			checked_row(0, 0, 1'b1),
			write_row(REG_SPARE_LO, 16'hFFFF),  // ignored
			write_row(REG_SPARE_HI, 16'h0000),
			checked_row(1501, 1500, 1'b0),
			// full gains drive the accumulator into saturation both ways
			write_row(REG_KP, 16'hFFFF),
			write_row(REG_HALF_ITI, 16'hFFFF),
			write_row(REG_TD, 16'hFFFF),
			write_row(REG_SEP, 16'hFFFF),
			write_row(REG_TOP, 16'hFFFF),
			write_row(REG_MIN, 16'h0000),
			sample_row(32767),
			sample_row(32767),
			sample_row(-32768),
			sample_row(-32768),
			// top speed zero forces every output to zero
			write_row(REG_TOP, 16'h0000),
			checked_row(5, 0, 1'b1),
			checked_row(-7, 0, 1'b1),
			// min speed above top speed: magnitude becomes min speed
			write_row(REG_TOP, 16'd100),
			write_row(REG_MIN, 16'hFFFF),
			write_row(REG_KP, 16'd256),
			write_row(REG_HALF_ITI, 16'h0000),
			write_row(REG_TD, 16'h0000),
			sample_row(3),
			sample_row(-3),
			// zero gain holds the accumulator, zero threshold disables integral
			write_row(REG_KP, 16'h0000),
			write_row(REG_SEP, 16'h0000),
			sample_row(12345),
			sample_row(0)
		};

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_WRITE) begin
				if (!writing) begin
					wait_until_drained();
					writing = 1'b1;
				end
				write_register(directed[i].index, directed[i].data);
			end else begin
				if (writing) begin
					cfg_we <= 1'b0;
					writing = 1'b0;
				end
				send_error(directed[i].err, directed[i].typed, directed[i].want);
			end
		end

		// Random phases, each under a fresh setting
		for (int phase = 0; phase < RAND_PHASES; phase++) begin
			wait_until_drained();
			write_register(REG_KP, pick_setting(1024, 1'b0));
			write_register(REG_HALF_ITI, pick_setting(65535, 1'b0));
			write_register(REG_TD, pick_setting(128, 1'b0));
			write_register(REG_TOP, pick_setting(4000, 1'b1));
			write_register(REG_MIN, pick_setting(600, 1'b1));
			write_register(REG_SEP, pick_setting(200, 1'b1));
			if ($urandom_range(0, 3) == 0)
				write_register($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
					CFG_DATA_W'($urandom));
			cfg_we <= 1'b0;
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// long output stall while requests keep coming
				if (phase == 1 && n == 30) hold_off_req = 1'b1;
				send_error(random_error(), 1'b0, no_cmd);
			end
		end

		wait_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0 && expected_speed_q.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	// Receiver: ready follows random 32-bit patterns shifted out bit by bit, or one long hold-off on request
	initial begin : receiver
		int hold_left;
		int pat_left;
		logic [31:0] pat;
		hold_left = 0;
		pat_left = 0;
		pat = '0;
		speed_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				speed_ch.ready <= 1'b0;
				hold_left--;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				speed_ch.ready <= 1'b0;
			end else begin
				if (pat_left == 0) begin
					case ($urandom_range(0, 3))
						0: pat = '1;
						1: pat = $urandom;
						2: pat = $urandom & $urandom;
						default: pat = $urandom | $urandom;
					endcase
					pat_left = 32;
				end
				speed_ch.ready <= pat[0];
				pat = pat >> 1;
				pat_left--;
			end
		end
	end

	// Result check against the oldest expectation
	always @(posedge clk) begin : result_check
		speed_cmd_t want;
		if (arst_n && speed_ch.valid && speed_ch.ready) begin
			if (expected_speed_q.size() == 0) begin
				$error("unexpected result: speed_out %0d integral_active %0b",
					speed_ch.speed_out, speed_ch.integral_active);
				fail_count++;
			end else begin
				want = expected_speed_q.pop_front();
				if (speed_ch.speed_out !== want.speed) begin
					$error("speed_out: expected %0d, actual %0d", want.speed,
						speed_ch.speed_out);
					fail_count++;
				end
				if (speed_ch.integral_active !== want.integral) begin
					$error("integral_active: expected %0b, actual %0b", want.integral,
						speed_ch.integral_active);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on cycles with no accepted request on either side
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if (!arst_n || (err_ch.valid && err_ch.ready) || (speed_ch.valid && speed_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

endmodule

[filelist.f]
design/ipsl_pkg.sv
design/ipsl_err_if.sv
design/ipsl_speed_if.sv
design/ipsl_cfg.sv
design/ipsl_mac.sv
design/ipsl_ctrl.sv
design/incremental_pid_speed_limiter.sv
bench/incremental_pid_speed_limiter_tb.sv
